// File: src/htpd_pkg.sv
// Shared types and constants for the Huffman tree-walk pixel decoder.
// Used by every module of the block; depends on nothing else.
package htpd_pkg;

  localparam int unsigned ChildW = 9;   // width of a child pointer and of node_index
  localparam int unsigned PixW   = 8;   // pixel value width
  localparam int unsigned PosW   = 12;  // raster column and row width
  localparam int unsigned DimW   = 13;  // image_width and image_height register width
  localparam int unsigned CfgIdxW = 2;  // configuration index width
  localparam int unsigned ByteW  = 8;   // bits in one packed data byte
  localparam int unsigned BitCntW = 4;  // holds 0 .. ByteW

  localparam logic [DimW-1:0] MaxDim = 13'd4096;
  localparam logic [PixW-1:0] PixSat = 8'd255;

  typedef enum logic {
    OpNode = 1'b0,
    OpData = 1'b1
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 2'd0,
    CfgHeight = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFlush
  } state_e;

  // One tree node: leaf flag, child taken on a 0 bit, child taken on a 1 bit.
  typedef struct packed {
    logic              leaf;
    logic [ChildW-1:0] left;
    logic [ChildW-1:0] right;
  } node_t;

  // Raster position, final-pixel flag and end-of-image status.
  typedef struct packed {
    logic [PosW-1:0] col;
    logic [PosW-1:0] row;
    logic            frame_done;
    logic            complete;
  } pos_t;

endpackage

// File: src/htpd_tree_mem.sv
// Code tree storage: one write port, one read port at a chosen node and one
// fixed read port at the root, both with registered read data. Uses htpd_pkg.
module htpd_tree_mem #(
  parameter int unsigned TREE_NODES = 512
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(TREE_NODES)-1:0] waddr_i,
  input  htpd_pkg::node_t               wdata_i,
  input  logic [$clog2(TREE_NODES)-1:0] raddr_i,
  output htpd_pkg::node_t               rdata_o,
  output htpd_pkg::node_t               root_o
);

  localparam int unsigned AW = $clog2(TREE_NODES);
  localparam logic [AW-1:0] RootAddr = AW'(TREE_NODES - 1);

  htpd_pkg::node_t mem [TREE_NODES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
    root_o  <= mem[RootAddr];
  end

endmodule

// File: src/htpd_raster.sv
// Raster position counters with clamped image dimensions and end-of-image flag.
// Uses htpd_pkg for widths and the pos_t status struct.
module htpd_raster (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [htpd_pkg::DimW-1:0]   width_i,
  input  logic [htpd_pkg::DimW-1:0]   height_i,
  input  logic                        advance_i,
  output htpd_pkg::pos_t              pos_o
);

  logic [htpd_pkg::PosW-1:0] col_q, col_d;
  logic [htpd_pkg::PosW-1:0] row_q, row_d;
  logic                      complete_q, complete_d;
  logic [htpd_pkg::DimW-1:0] w_eff, h_eff, col_inc, row_inc;
  logic                      row_end, frame_done;

  always_comb begin
    // A zero dimension acts as one, an oversized one as the maximum.
    if (width_i == '0) begin
      w_eff = htpd_pkg::DimW'(1);
    end else if (width_i > htpd_pkg::MaxDim) begin
      w_eff = htpd_pkg::MaxDim;
    end else begin
      w_eff = width_i;
    end
    if (height_i == '0) begin
      h_eff = htpd_pkg::DimW'(1);
    end else if (height_i > htpd_pkg::MaxDim) begin
      h_eff = htpd_pkg::MaxDim;
    end else begin
      h_eff = height_i;
    end
    col_inc    = htpd_pkg::DimW'(col_q) + htpd_pkg::DimW'(1);
    row_inc    = htpd_pkg::DimW'(row_q) + htpd_pkg::DimW'(1);
    row_end    = (col_inc >= w_eff);
    frame_done = row_end && (row_inc >= h_eff);
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    complete_d = complete_q;
    if (advance_i) begin
      if (row_end) begin
        col_d = '0;
        if (frame_done) begin
          complete_d = 1'b1;
        end else begin
          row_d = row_inc[htpd_pkg::PosW-1:0];
        end
      end else begin
        col_d = col_inc[htpd_pkg::PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      complete_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      complete_q <= complete_d;
    end
  end

  assign pos_o = '{col: col_q, row: row_q, frame_done: frame_done, complete: complete_q};

endmodule

// File: src/htpd_seq.sv
// Bit sequencer of the tree walk: steps one code bit a cycle through the tree
// memory unless the output stalls, holds one pixel back to mark the last of
// each byte, and drives the output register. Uses htpd_pkg.
module htpd_seq #(
  parameter int unsigned TREE_NODES = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [htpd_pkg::ChildW-1:0]   node_index_i,
  input  logic [htpd_pkg::ByteW-1:0]    data_byte_i,
  output logic                          mem_we_o,
  output logic [$clog2(TREE_NODES)-1:0] mem_raddr_o,
  input  htpd_pkg::node_t               mem_rdata_i,
  input  htpd_pkg::node_t               mem_root_i,
  input  htpd_pkg::pos_t                pos_i,
  output logic                          advance_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [htpd_pkg::PixW-1:0]     pixel_value_o,
  output logic [htpd_pkg::PosW-1:0]     pixel_column_o,
  output logic [htpd_pkg::PosW-1:0]     pixel_row_o,
  output logic                          frame_done_o,
  output logic                          last_o
);

  localparam int unsigned AW = $clog2(TREE_NODES);
  localparam int unsigned NW = (AW > htpd_pkg::ChildW) ? AW : htpd_pkg::ChildW;
  localparam logic [NW-1:0] Root    = NW'(TREE_NODES - 1);
  localparam logic [NW:0]   NodeCnt = (NW + 1)'(TREE_NODES);

  htpd_pkg::state_e state_q, state_d;

  logic [NW-1:0]                  walk_q, walk_d;
  logic                           check_q, check_d;
  logic [htpd_pkg::BitCntW-1:0]   bits_q, bits_d;
  logic [htpd_pkg::ByteW-1:0]     byte_q, byte_d;

  logic                           pend_valid_q, pend_valid_d;
  logic [htpd_pkg::PixW-1:0]      pend_value_q;
  logic [htpd_pkg::PosW-1:0]      pend_col_q, pend_row_q;
  logic                           pend_done_q;

  logic                           out_valid_q, out_valid_d;
  logic [htpd_pkg::PixW-1:0]      out_value_q;
  logic [htpd_pkg::PosW-1:0]      out_col_q, out_row_q;
  logic                           out_done_q, out_last_q;

  logic                           accept, accept_data;
  logic                           in_range, is_leaf, out_free, stall, leaf_take;
  logic                           complete_eff, go_bit, load_mid, load_fin;
  htpd_pkg::node_t                cur_ent, eff_ent;
  logic [htpd_pkg::ChildW-1:0]    next_child;
  logic [htpd_pkg::PixW-1:0]      leaf_value;

  always_comb begin
    accept      = in_valid_i && (state_q == htpd_pkg::StIdle);
    accept_data = accept && (opcode_i == htpd_pkg::OpData);
    in_range    = ((NW + 1)'(walk_q) < NodeCnt);
    cur_ent     = in_range ? mem_rdata_i : '0;
    is_leaf     = (state_q == htpd_pkg::StWalk) && check_q && cur_ent.leaf;
    out_free    = !out_valid_q || out_ready_i;
    stall       = is_leaf && pend_valid_q && !out_free;
    leaf_take   = is_leaf && !stall;
    eff_ent     = is_leaf ? mem_root_i : cur_ent;
    complete_eff = is_leaf ? pos_i.frame_done : pos_i.complete;
    go_bit      = (state_q == htpd_pkg::StWalk) && !stall && (bits_q != '0) && !complete_eff;
    next_child  = byte_q[htpd_pkg::ByteW-1] ? eff_ent.right : eff_ent.left;
    leaf_value  = (|walk_q[NW-1:htpd_pkg::PixW]) ? htpd_pkg::PixSat
                                                  : walk_q[htpd_pkg::PixW-1:0];
    load_mid    = leaf_take && pend_valid_q;
    load_fin    = (state_q == htpd_pkg::StFlush) && pend_valid_q && out_free;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      htpd_pkg::StIdle: begin
        if (accept_data) begin
          state_d = htpd_pkg::StWalk;
        end
      end
      htpd_pkg::StWalk: begin
        if (!stall && !go_bit) begin
          state_d = htpd_pkg::StFlush;
        end
      end
      htpd_pkg::StFlush: begin
        if (!pend_valid_q || out_free) begin
          state_d = htpd_pkg::StIdle;
        end
      end
      default: state_d = htpd_pkg::StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    walk_d       = walk_q;
    check_d      = check_q;
    bits_d       = bits_q;
    byte_d       = byte_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (accept_data) begin
      byte_d  = data_byte_i;
      bits_d  = htpd_pkg::BitCntW'(htpd_pkg::ByteW);
      check_d = 1'b0;
    end

    if (state_q == htpd_pkg::StWalk && !stall) begin
      check_d = go_bit;
      if (go_bit) begin
        walk_d = NW'(next_child);
        bits_d = bits_q - htpd_pkg::BitCntW'(1);
        byte_d = {byte_q[htpd_pkg::ByteW-2:0], 1'b0};
      end else if (is_leaf) begin
        walk_d = Root;
      end
    end

    if (leaf_take) begin
      pend_valid_d = 1'b1;
    end else if (load_fin) begin
      pend_valid_d = 1'b0;
    end
    if (load_mid || load_fin) begin
      out_valid_d = 1'b1;
    end

    in_ready_o  = (state_q == htpd_pkg::StIdle);
    mem_we_o    = accept && (opcode_i == htpd_pkg::OpNode)
                  && ((NW + 1)'(node_index_i) < NodeCnt);
    mem_raddr_o = AW'(walk_d);
    advance_o   = leaf_take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= htpd_pkg::StIdle;
      walk_q       <= Root;
      check_q      <= 1'b0;
      bits_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      check_q      <= check_d;
      bits_q       <= bits_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (leaf_take) begin
      pend_value_q <= leaf_value;
      pend_col_q   <= pos_i.col;
      pend_row_q   <= pos_i.row;
      pend_done_q  <= pos_i.frame_done;
    end
    if (load_mid || load_fin) begin
      out_value_q <= pend_value_q;
      out_col_q   <= pend_col_q;
      out_row_q   <= pend_row_q;
      out_done_q  <= pend_done_q;
      out_last_q  <= load_fin;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_value_q;
  assign pixel_column_o = out_col_q;
  assign pixel_row_o    = out_row_q;
  assign frame_done_o   = out_done_q;
  assign last_o         = out_last_q;

endmodule

// File: src/huffman_tree_pixel_decoder.sv
// Huffman tree-walk pixel decoder. A tree-node write is made in the cycle it
// is accepted. A data byte is accepted, walked one bit step at a time through
// the tree memory, given one last leaf check and then flushed to release the
// byte's final pixel. Output back-pressure can stall the walk. Reset (rst_ni,
// asynchronous, active low) sets the walk to the root, clears the raster
// counters and the end-of-image flag and sets both dimensions to one; the
// tree memory is not cleared.
module huffman_tree_pixel_decoder #(
  parameter int unsigned TREE_NODES = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input item channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [htpd_pkg::ChildW-1:0]   node_index_i,
  input  logic                          node_is_leaf_i,
  input  logic [htpd_pkg::ChildW-1:0]   left_child_i,
  input  logic [htpd_pkg::ChildW-1:0]   right_child_i,
  input  logic [htpd_pkg::ByteW-1:0]    data_byte_i,
  // Pixel result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [htpd_pkg::PixW-1:0]     pixel_value_o,
  output logic [htpd_pkg::PosW-1:0]     pixel_column_o,
  output logic [htpd_pkg::PosW-1:0]     pixel_row_o,
  output logic                          frame_done_o,
  output logic                          last_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [htpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [htpd_pkg::DimW-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(TREE_NODES);

  // Image dimensions. Writes to an index beyond the two registers are
  // accepted and dropped.
  logic [htpd_pkg::DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= htpd_pkg::DimW'(1);
      height_q <= htpd_pkg::DimW'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == htpd_pkg::CfgWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_index_i == htpd_pkg::CfgHeight) begin
        height_q <= cfg_data_i;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // The tree memory is read every cycle at the node the walk will stand on
  // next, so its registered read data always holds the current node's entry.
  // A second fixed port keeps the root's entry ready for the step after a
  // leaf, when the walk jumps back to the root within the same cycle.
  logic                 mem_we;
  logic [AW-1:0]        mem_raddr;
  htpd_pkg::node_t      mem_wdata, mem_rdata, mem_root;
  htpd_pkg::pos_t       pos;
  logic                 advance;

  assign mem_wdata = '{leaf: node_is_leaf_i, left: left_child_i, right: right_child_i};

  htpd_tree_mem #(
    .TREE_NODES (TREE_NODES)
  ) u_tree_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(node_index_i)),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .root_o  (mem_root)
  );

  // Column and row counters advance once per decoded pixel. They also tell
  // the sequencer whether the pixel being found is the image's final one,
  // after which the remaining bits are padding and are ignored.
  htpd_raster u_raster (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .width_i   (width_q),
    .height_i  (height_q),
    .advance_i (advance),
    .pos_o     (pos)
  );

  // The sequencer holds each pixel back until the next one is found or the
  // byte runs out, so that the last pixel of a byte can be flagged.
  htpd_seq #(
    .TREE_NODES (TREE_NODES)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .node_index_i   (node_index_i),
    .data_byte_i    (data_byte_i),
    .mem_we_o       (mem_we),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .mem_root_i     (mem_root),
    .pos_i          (pos),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pixel_value_o  (pixel_value_o),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .frame_done_o   (frame_done_o),
    .last_o         (last_o)
  );

endmodule

// File: src/htpd_checker.sv
// Port-level checks for the Huffman tree-walk pixel decoder, bound to the top
// level. Uses htpd_pkg for widths and the opcode codes.
module htpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          opcode_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [htpd_pkg::PixW-1:0]     pixel_value_o,
  input logic [htpd_pkg::PosW-1:0]     pixel_column_o,
  input logic [htpd_pkg::PosW-1:0]     pixel_row_o,
  input logic                          frame_done_o,
  input logic                          last_o
);

  // A stalled pixel transaction keeps its value, position and last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_value_o)
      && $stable(pixel_column_o) && $stable(pixel_row_o) && $stable(last_o))
    else $error("pixel payload changed while stalled");

  // The image's final pixel is always the last one its byte produces.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_o)
    else $error("final pixel not marked last");

  // Once the decoder is idle, any pixel still waiting closes its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> last_o)
    else $error("idle with a pixel of an unfinished byte");

  // A data byte keeps the decoder busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == htpd_pkg::OpData) |=> !in_ready_o)
    else $error("ready straight after a data byte");

endmodule

bind huffman_tree_pixel_decoder htpd_checker u_htpd_checker (.*);
